[design/btmx_pkg.sv]
// Shared types and constants of the binary trie maximum-XOR block.
// Used by btmx_ctrl, btmx_dp and binary_trie_max_xor; depends on nothing.
package btmx_pkg;

    // Trie geometry
    localparam int KEY_BITS      = 32;
    localparam int NODE_CAPACITY = 131072;
    localparam int NODE_W        = $clog2(NODE_CAPACITY);
    localparam int LEVEL_W       = (KEY_BITS > 2) ? $clog2(KEY_BITS) : 1;

    // Stream field widths
    localparam int KIND_W   = 2;
    localparam int KEY_IN_W = 32;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 32;

    typedef logic [NODE_W-1:0]   t_node;
    typedef logic [2*NODE_W-1:0] t_row;    // {link for bit one, link for bit zero}
    typedef logic [KIND_W-1:0]   t_kind;

    // Item kinds; every other code runs as a query
    localparam t_kind KIND_CLEAR  = 2'd0;
    localparam t_kind KIND_INSERT = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUERY_OK = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_CLEARED  = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_IWALK,
        S_ICHECK,
        S_APAR,
        S_ANEW,
        S_QWALK,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    clear;
        logic    iwalk;
        logic    qwalk;
        logic    apar;
        logic    anew;
        logic    set_status;
        t_status status;
        logic    emit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_kind kind;
        logic  empty;
        logic  link_miss;
        logic  at_leaf;
        logic  full;
        logic  out_free;
    } t_stat;

endpackage

[design/btmx_ctrl.sv]
// Sequencer of the trie block: accepts one item, steps the walk and allocation
// phases and hands the result to the output register. Depends on btmx_pkg.
module btmx_ctrl import btmx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.status = ST_QUERY_OK;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.kind)
                    KIND_CLEAR: begin
                        o_cmd.clear      = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_CLEARED;
                        n_state          = S_RESULT;
                    end
                    KIND_INSERT: begin
                        n_state = S_IWALK;
                    end
                    default: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                            n_state          = S_RESULT;
                        end else begin
                            n_state = S_QWALK;
                        end
                    end
                endcase
            end
            S_IWALK: begin
                o_cmd.iwalk = 1'b1;
                if (i_stat.link_miss) begin
                    n_state = S_ICHECK;
                end else if (i_stat.at_leaf) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_INSERTED;
                    n_state          = S_RESULT;
                end
            end
            S_ICHECK: begin
                if (i_stat.full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                    n_state          = S_RESULT;
                end else begin
                    n_state = S_APAR;
                end
            end
            S_APAR: begin
                o_cmd.apar = 1'b1;
                n_state    = S_ANEW;
            end
            S_ANEW: begin
                o_cmd.anew = 1'b1;
                if (i_stat.at_leaf) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_INSERTED;
                    n_state          = S_RESULT;
                end
            end
            S_QWALK: begin
                o_cmd.qwalk = 1'b1;
                if (i_stat.at_leaf) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_QUERY_OK;
                    n_state          = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/btmx_dp.sv]
// Datapath of the trie block: root links, node link store, leaf key store,
// walk registers, allocation counter and output register. Depends on btmx_pkg.
module btmx_dp import btmx_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [KEY_IN_W-1:0] i_key,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [OUT_W-1:0]    o_partner,
    output logic [OUT_W-1:0]    o_xor
);

    // Node store: row per node, node zero lives in r_root_row
    t_row                mem_link [NODE_CAPACITY];
    logic [KEY_BITS-1:0] mem_leaf [NODE_CAPACITY];

    logic [KEY_BITS-1:0] r_key;
    t_kind               r_kind;
    logic [LEVEL_W-1:0]  r_level;
    logic                r_cur_root;
    t_node               r_cur_node;
    t_row                r_root_row;
    t_node               r_used;
    logic                r_empty;
    t_row                r_rd_row;
    logic [KEY_BITS-1:0] r_rd_leaf;
    t_status             r_status;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [OUT_W-1:0]    r_out_partner;
    logic [OUT_W-1:0]    r_out_xor;

    t_row                cur_row;
    logic                key_bit;
    logic                low_bit;
    logic                at_leaf;
    t_node               link_same;
    t_node               link_opp;
    t_node               q_next;
    t_node               new_id;
    t_node               new_next;
    t_row                new_row;
    t_row                par_row;
    logic                link_we;
    t_node               link_waddr;
    t_row                link_wdata;
    logic                link_re;
    t_node               link_raddr;
    logic                leaf_we;
    t_node               leaf_waddr;
    logic                leaf_re;
    logic                out_free;
    logic [NODE_W:0]     need_total;

    // Select the links of the node being visited
    always_comb begin
        cur_row   = r_cur_root ? r_root_row : r_rd_row;
        key_bit   = r_key[r_level];
        low_bit   = r_key[r_level - 1'b1];
        at_leaf   = (r_level == '0);
        link_same = key_bit ? cur_row[2*NODE_W-1:NODE_W] : cur_row[NODE_W-1:0];
        link_opp  = key_bit ? cur_row[NODE_W-1:0] : cur_row[2*NODE_W-1:NODE_W];
        q_next    = (link_opp != '0) ? link_opp : link_same;
    end

    // Build rows for allocation: parent gets the first new node, each new node
    // links to the next one, the leaf gets no children
    always_comb begin
        new_id   = r_used + 1'b1;
        new_next = new_id + 1'b1;
        if (at_leaf) begin
            new_row = '0;
        end else if (low_bit) begin
            new_row = {new_next, {NODE_W{1'b0}}};
        end else begin
            new_row = {{NODE_W{1'b0}}, new_next};
        end
        if (key_bit) begin
            par_row = {new_id, cur_row[NODE_W-1:0]};
        end else begin
            par_row = {cur_row[2*NODE_W-1:NODE_W], new_id};
        end
    end

    // Memory port control
    always_comb begin
        link_we    = (i_cmd.apar && !r_cur_root) || i_cmd.anew;
        link_waddr = i_cmd.anew ? new_id : r_cur_node;
        link_wdata = i_cmd.anew ? new_row : par_row;
        link_re    = ((i_cmd.iwalk && (link_same != '0)) || i_cmd.qwalk) && !at_leaf;
        link_raddr = i_cmd.iwalk ? link_same : q_next;
        leaf_we    = ((i_cmd.iwalk && (link_same != '0)) || i_cmd.anew) && at_leaf;
        leaf_waddr = i_cmd.anew ? new_id : link_same;
        leaf_re    = i_cmd.qwalk && at_leaf;
    end

    // Nodes needed by an insert that left the existing path at this level
    always_comb begin
        need_total = {1'b0, r_used} + (NODE_W + 1)'(r_level) + 1'b1;
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.kind      = r_kind;
        o_stat.empty     = r_empty;
        o_stat.link_miss = (link_same == '0);
        o_stat.at_leaf   = at_leaf;
        o_stat.full      = (need_total > (NODE_W + 1)'(NODE_CAPACITY - 1));
        o_stat.out_free  = out_free;
    end

    // Link store
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            mem_link[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            r_rd_row <= mem_link[link_raddr];
        end
    end

    // Leaf key store
    always_ff @(posedge i_clk) begin
        if (leaf_we) begin
            mem_leaf[leaf_waddr] <= r_key;
        end
        if (leaf_re) begin
            r_rd_leaf <= mem_leaf[q_next];
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_root <= 1'b1;
        end else if (i_cmd.load) begin
            r_cur_root <= 1'b1;
        end else if (link_re) begin
            r_cur_root <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= KEY_BITS'(i_key);
            r_kind  <= i_kind;
            r_level <= LEVEL_W'(KEY_BITS - 1);
        end else if (link_re || (i_cmd.anew && !at_leaf)) begin
            r_level <= r_level - 1'b1;
        end
        if (link_re) begin
            r_cur_node <= link_raddr;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    // Trie bookkeeping: root links, allocation count, empty flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_row <= '0;
            r_used     <= '0;
            r_empty    <= 1'b1;
        end else if (i_cmd.clear) begin
            r_root_row <= '0;
            r_used     <= '0;
            r_empty    <= 1'b1;
        end else begin
            if (i_cmd.apar && r_cur_root) begin
                r_root_row <= par_row;
            end
            if (i_cmd.anew) begin
                r_used <= new_id;
            end
            if (leaf_we) begin
                r_empty <= 1'b0;
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            if (r_status == ST_QUERY_OK) begin
                r_out_partner <= OUT_W'(r_rd_leaf);
                r_out_xor     <= OUT_W'(r_key ^ r_rd_leaf);
            end else begin
                r_out_partner <= '0;
                r_out_xor     <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_partner   = r_out_partner;
    assign o_xor       = r_out_xor;

endmodule

[design/binary_trie_max_xor.sv]
// Top level of the binary trie maximum-XOR block: stream ports around the
// sequencer and the datapath. Depends on btmx_pkg, btmx_ctrl and btmx_dp.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser[1:0] kind, tdata[31:0] key_value
//  m_axis    out        tuser[2:0] status, tdata[31:0] partner_key,
//                       tdata[63:32] best_xor
//
// One item at a time. A query steps through accept, decode, one trie level
// per cycle through the node store read port, and result; an insert walks the
// levels it finds, checks the free count, writes the parent row, then one node
// row per cycle for every node it adds. A clear or an empty query steps through
// accept, decode and result.
// A result waits in the output register while the next beat is accepted.
// Reset empties the trie at once; the node stores need no clearing pass.
module binary_trie_max_xor import btmx_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [KEY_IN_W-1:0]   s_axis_tdata,   // [31:0] key_value
    input  logic [KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [2*OUT_W-1:0]    m_axis_tdata,   // [31:0] partner_key, [63:32] best_xor
    output logic [STATUS_W-1:0]   m_axis_tuser    // [2:0] status
);

    t_cmd             cmd;
    t_stat            stat;
    logic [OUT_W-1:0] partner;
    logic [OUT_W-1:0] best_xor;

    btmx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    btmx_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_kind      (s_axis_tuser),
        .i_key       (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_partner   (partner),
        .o_xor       (best_xor)
    );

    assign m_axis_tdata = {best_xor, partner};

endmodule
